### src/rbd_pkg.sv
`default_nettype none
package rbd_pkg;
	localparam int MAX_WIDTH_DEF = 4096;
	localparam int MAX_BLOCK_DEF = 16;

	localparam int SUM_W  = 24;
	localparam int PIX_W  = 8;
	localparam int POS_W  = 12;
	localparam int IDX_W  = 2;
	localparam int CFG_W  = 13;

	localparam logic [IDX_W-1:0] REG_BLOCK_SIZE   = 2'd0;
	localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
	localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

	localparam logic [4:0]       BLOCK_RESET  = 5'd2;
	localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;
endpackage
`default_nettype wire

### src/rms_box_downsample_unit.sv
`default_nettype none
// Channel   Direction  Payload
// s_axis    in         tdata = red_in, green_in, blue_in
// m_axis    out        tdata = red_out, green_out, blue_out, out_column, out_row;
//                      tlast = frame_last
// cfg       in         cfg_index, cfg_data (block_size, image_width, image_height)
//
// A pixel inside a whole block is accepted, then reads its accumulator, then is
// added and written back; a pixel outside every whole block is only accepted. A
// pixel that closes a block then goes through division of each sum by the block
// area and a square root, and then loads the output register.
// Reset clears the control state; the accumulator memory is written by the
// first pixel of each block before it is read, so it needs no clearing.
// A finished result waits in the output register while the next pixels flow; the
// next result stalls the input until that register is taken. Configuration is
// accepted only while no pixel is in flight, and it holds off the input.
module rms_box_downsample_unit import rbd_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [23:0]          s_axis_tdata,  // red_in, green_in, blue_in
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	output logic [47:0]               m_axis_tdata,  // red_out, green_out, blue_out,
	                                                 // out_column, out_row
	output logic                      m_axis_tlast,  // frame_last
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [IDX_W-1:0]     cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);
	localparam int DW = $clog2(MAX_WIDTH + 1);
	localparam int AW = $clog2(MAX_WIDTH);
	localparam int BW = $clog2(MAX_BLOCK + 1);
	localparam int AR_W = 2 * BW;
	localparam int SQ_W = 2 * PIX_W;
	localparam int DIV_STEPS = SUM_W;
	localparam int SQRT_STEPS = SQ_W / 2;
	localparam int CNT_W = $clog2(DIV_STEPS + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1;
	localparam logic [2:0] S_ADD  = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_SQRT = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	logic [2:0] state_q;
	logic [4:0] block_q;
	logic [CFG_W-1:0] width_q, height_q;

	logic [BW-1:0] n;
	logic [DW-1:0] w, h;
	logic [AR_W-1:0] area;

	always_comb begin
		if (block_q == 5'd0) n = BW'(1);
		else if (32'(block_q) > MAX_BLOCK) n = BW'(MAX_BLOCK);
		else n = BW'(block_q);
		if (width_q == '0) w = DW'(1);
		else if (32'(width_q) > MAX_WIDTH) w = DW'(MAX_WIDTH);
		else w = DW'(width_q);
		if (height_q == '0) h = DW'(1);
		else if (32'(height_q) > MAX_WIDTH) h = DW'(MAX_WIDTH);
		else h = DW'(height_q);
	end

	logic [DW-1:0] scol_q, srow_q, ocol_q, orow_q, cbase_q, rbase_q;
	logic [BW-1:0] cib_q, rib_q;

	// A block is kept only when it fits whole inside the image; the last block
	// of a frame is the one after which no further block fits, right or below.
	logic in_block, is_last, frame_end;
	always_comb begin
		in_block = ((DW+1)'(cbase_q) + (DW+1)'(n) <= (DW+1)'(w))
			&& ((DW+1)'(rbase_q) + (DW+1)'(n) <= (DW+1)'(h));
		is_last = (cib_q == n - BW'(1)) && (rib_q == n - BW'(1));
		frame_end = ((DW+2)'(cbase_q) + (DW+2)'(2 * n) > (DW+2)'(w))
			&& ((DW+2)'(rbase_q) + (DW+2)'(2 * n) > (DW+2)'(h));
		area = AR_W'(n) * AR_W'(n);
	end

	logic accept;
	assign s_axis_tready = (state_q == S_IDLE) && !cfg_valid;
	assign accept = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = (state_q == S_IDLE);

	logic [3*SUM_W-1:0] mem [MAX_WIDTH];
	logic [3*SUM_W-1:0] rd_q;
	logic [AW-1:0] addr_q;
	logic [23:0] pix_q;
	logic first_q, last_q, flast_q;
	logic [POS_W-1:0] ocol_hold_q, orow_hold_q;
	logic [3*SUM_W-1:0] sum_new;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum_new[c*SUM_W +: SUM_W] = (first_q ? SUM_W'(0) : rd_q[c*SUM_W +: SUM_W])
				+ SUM_W'(SQ_W'(pix_q[c*PIX_W +: PIX_W]) * SQ_W'(pix_q[c*PIX_W +: PIX_W]));
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[addr_q];
		if (state_q == S_ADD) begin
			mem[addr_q] <= sum_new;
		end
	end

	// Configuration registers and position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_q <= BLOCK_RESET;
			width_q <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			scol_q <= '0; srow_q <= '0; ocol_q <= '0; orow_q <= '0;
			cbase_q <= '0; rbase_q <= '0; cib_q <= '0; rib_q <= '0;
		end else if (cfg_valid && cfg_ready && (cfg_index == REG_BLOCK_SIZE
			|| cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT)) begin
			case (cfg_index)
				REG_BLOCK_SIZE: block_q <= cfg_data[4:0];
				REG_IMAGE_WIDTH: width_q <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
			scol_q <= '0; srow_q <= '0; ocol_q <= '0; orow_q <= '0;
			cbase_q <= '0; rbase_q <= '0; cib_q <= '0; rib_q <= '0;
		end else if (accept) begin
			if (scol_q + DW'(1) >= w) begin
				scol_q <= '0; cib_q <= '0; ocol_q <= '0; cbase_q <= '0;
				if (srow_q + DW'(1) >= h) begin
					srow_q <= '0; rib_q <= '0; orow_q <= '0; rbase_q <= '0;
				end else begin
					srow_q <= srow_q + DW'(1);
					if (rib_q + BW'(1) >= n) begin
						rib_q <= '0;
						orow_q <= orow_q + DW'(1);
						rbase_q <= srow_q + DW'(1);
					end else begin
						rib_q <= rib_q + BW'(1);
					end
				end
			end else begin
				scol_q <= scol_q + DW'(1);
				if (cib_q + BW'(1) >= n) begin
					cib_q <= '0;
					ocol_q <= ocol_q + DW'(1);
					cbase_q <= scol_q + DW'(1);
				end else begin
					cib_q <= cib_q + BW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_q <= s_axis_tdata;
			addr_q <= ocol_q[AW-1:0];
			first_q <= (cib_q == '0) && (rib_q == '0);
			last_q <= is_last;
			flast_q <= frame_end;
			ocol_hold_q <= POS_W'(ocol_q);
			orow_hold_q <= POS_W'(orow_q);
		end
	end

	// Three lanes share one sequencer: restoring division, then square root.
	logic [2:0][SUM_W-1:0] dq_q;
	logic [2:0][AR_W-1:0] rem_q;
	logic [2:0][SQ_W-1:0] v_q, res_q;
	logic [SQ_W-1:0] bit_q;
	logic [CNT_W-1:0] cnt_q;
	logic [2:0][AR_W:0] trial;
	logic [2:0][SQ_W-1:0] cand;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			trial[c] = {rem_q[c], dq_q[c][SUM_W-1]};
			cand[c] = res_q[c] + bit_q;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_ADD) begin
			for (int c = 0; c < 3; c++) begin
				dq_q[c] <= sum_new[c*SUM_W +: SUM_W];
				rem_q[c] <= '0;
			end
		end else if (state_q == S_DIV) begin
			for (int c = 0; c < 3; c++) begin
				if (trial[c] >= (AR_W+1)'(area)) begin
					rem_q[c] <= AR_W'(trial[c] - (AR_W+1)'(area));
					dq_q[c] <= {dq_q[c][SUM_W-2:0], 1'b1};
				end else begin
					rem_q[c] <= AR_W'(trial[c]);
					dq_q[c] <= {dq_q[c][SUM_W-2:0], 1'b0};
				end
			end
			bit_q <= SQ_W'(1) << (SQ_W - 2);
			if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
				for (int c = 0; c < 3; c++) begin
					res_q[c] <= '0;
				end
			end
		end else if (state_q == S_SQRT) begin
			for (int c = 0; c < 3; c++) begin
				if (v_q[c] >= cand[c]) begin
					v_q[c] <= v_q[c] - cand[c];
					res_q[c] <= (res_q[c] >> 1) + bit_q;
				end else begin
					res_q[c] <= res_q[c] >> 1;
				end
			end
			bit_q <= bit_q >> 2;
		end
		// The quotient never exceeds the square of a pixel value.
		if (state_q == S_DIV && cnt_q == CNT_W'(DIV_STEPS - 1)) begin
			for (int c = 0; c < 3; c++) begin
				v_q[c] <= SQ_W'({dq_q[c][SUM_W-2:0], (trial[c] >= (AR_W+1)'(area))});
			end
		end
	end

	logic out_valid_q;
	logic [47:0] out_data_q;
	logic out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// In S_OUT the output flag is handled by the state itself.
			if (m_axis_tvalid && m_axis_tready && state_q != S_OUT) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (accept) state_q <= in_block ? S_READ : S_IDLE;
				S_READ: state_q <= S_ADD;
				S_ADD: begin
					cnt_q <= '0;
					state_q <= last_q ? S_DIV : S_IDLE;
				end
				S_DIV: begin
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						cnt_q <= '0;
						state_q <= S_SQRT;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				S_SQRT: begin
					if (cnt_q == CNT_W'(SQRT_STEPS - 1)) state_q <= S_OUT;
					else cnt_q <= cnt_q + CNT_W'(1);
				end
				S_OUT: begin
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && (!out_valid_q || m_axis_tready)) begin
			out_data_q <= {orow_hold_q, ocol_hold_q, res_q[2][PIX_W-1:0],
				res_q[1][PIX_W-1:0], res_q[0][PIX_W-1:0]};
			out_last_q <= flast_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;
	assign m_axis_tlast = out_last_q;
endmodule
`default_nettype wire

### tb/tb_rms_box_downsample_unit.sv
`default_nettype none
module tb_rms_box_downsample_unit;
	import rbd_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [11:0] column;
		logic [11:0] row;
		logic        last;
	} rms_pixel_t;

	// Tracks frame position and block sums, and holds the pixels still owed by the block.
	class rms_scoreboard;
		logic [4:0]  blk_reg;
		logic [12:0] width_reg;
		logic [12:0] height_reg;
		int unsigned sum_r[4096];
		int unsigned sum_g[4096];
		int unsigned sum_b[4096];
		int unsigned src_col, src_row, col_in_blk, row_in_blk, out_col, out_row;
		rms_pixel_t  owed[$];
		int          errors;

		function new();
			blk_reg = BLOCK_RESET;
			width_reg = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			errors = 0;
			restart();
		endfunction

		function void restart();
			src_col = 0; src_row = 0; col_in_blk = 0; row_in_blk = 0;
			out_col = 0; out_row = 0;
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			case (idx)
				REG_BLOCK_SIZE: blk_reg = val[4:0];
				REG_IMAGE_WIDTH: width_reg = val;
				REG_IMAGE_HEIGHT: height_reg = val;
				default: return;
			endcase
			restart();
		endfunction

		function int unsigned clamp_dim(int unsigned v);
			if (v == 0) return 1;
			if (v > 4096) return 4096;
			return v;
		endfunction

		function int unsigned floor_root(int unsigned v);
			int unsigned r;
			r = 0;
			while ((r + 1) * (r + 1) <= v) r++;
			return r;
		endfunction

		function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
			int unsigned n, w, h, k, area;
			bit first;
			rms_pixel_t p;
			n = (blk_reg == 0) ? 1 : (blk_reg > 16 ? 16 : blk_reg);
			w = clamp_dim(width_reg);
			h = clamp_dim(height_reg);
			if (out_col < w / n && out_row < h / n) begin
				k = out_col & 12'hFFF;
				first = (col_in_blk == 0) && (row_in_blk == 0);
				sum_r[k] = ((first ? 0 : sum_r[k]) + r * r) & 24'hFFFFFF;
				sum_g[k] = ((first ? 0 : sum_g[k]) + g * g) & 24'hFFFFFF;
				sum_b[k] = ((first ? 0 : sum_b[k]) + b * b) & 24'hFFFFFF;
				if (col_in_blk == n - 1 && row_in_blk == n - 1) begin
					area = n * n;
					p.red = 8'(floor_root(sum_r[k] / area));
					p.green = 8'(floor_root(sum_g[k] / area));
					p.blue = 8'(floor_root(sum_b[k] / area));
					p.column = 12'(out_col);
					p.row = 12'(out_row);
					p.last = (out_col == w / n - 1) && (out_row == h / n - 1);
					owed.push_back(p);
				end
			end
			col_in_blk++;
			if (col_in_blk >= n) begin
				col_in_blk = 0;
				out_col++;
			end
			src_col++;
			if (src_col >= w) begin
				src_col = 0; col_in_blk = 0; out_col = 0;
				row_in_blk++;
				if (row_in_blk >= n) begin
					row_in_blk = 0;
					out_row++;
				end
				src_row++;
				if (src_row >= h) restart();
			end
		endfunction

		function void check_pixel(rms_pixel_t got);
			rms_pixel_t want;
			if (owed.size() == 0) begin
				$display("%0t: unexpected output pixel, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			want = owed.pop_front();
			if (got.red !== want.red)
				$display("%0t: red expected %0d actual %0d", $time, want.red, got.red);
			if (got.green !== want.green)
				$display("%0t: green expected %0d actual %0d", $time, want.green, got.green);
			if (got.blue !== want.blue)
				$display("%0t: blue expected %0d actual %0d", $time, want.blue, got.blue);
			if (got.column !== want.column)
				$display("%0t: column expected %0d actual %0d", $time, want.column, got.column);
			if (got.row !== want.row)
				$display("%0t: row expected %0d actual %0d", $time, want.row, got.row);
			if (got.last !== want.last)
				$display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
			if (got !== want) errors++;
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [23:0]      s_axis_tdata = '0;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [47:0]      m_axis_tdata;
	logic             m_axis_tlast;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [IDX_W-1:0] cfg_index = REG_BLOCK_SIZE;
	logic [CFG_W-1:0] cfg_data = '0;

	rms_scoreboard board = new();
	bit            calm = 1'b0;
	int            pixels_sent = 0;

	always #1 clk = ~clk;

	rms_box_downsample_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Output side: each taken output pixel is checked; tready gets random stall bursts, none once the run turns calm.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				board.check_pixel({m_axis_tdata[7:0], m_axis_tdata[15:8],
					m_axis_tdata[23:16], m_axis_tdata[35:24], m_axis_tdata[47:36],
					m_axis_tlast});
		end
	end

	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (!calm && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			n = $urandom_range(1, 12);
			repeat (n) @(posedge clk);
		end
	end

	task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		if (!calm && $urandom_range(0, 7) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {b, g, r};
		do @(posedge clk); while (!s_axis_tready);
		board.note_pixel(r, g, b);
		pixels_sent++;
	endtask

	task automatic end_stream();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	// Ends the stream, waits until all owed pixels are out, then idles before returning.
	task automatic drain();
		end_stream();
		while (board.owed.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		board.write_reg(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic setup(logic [CFG_W-1:0] blk, logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
		drain();
		write_reg(REG_BLOCK_SIZE, blk);
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
	endtask

	task automatic random_frames(int pixels, int mode);
		repeat (pixels) begin
			case (mode)
				0: send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
				1: send_pixel(8'hFF, 8'hFF, 8'hFF);
				default: send_pixel($urandom_range(0, 1) ? 8'hFF : 8'h00, 8'($urandom),
					8'($urandom_range(250, 255)));
			endcase
		end
	endtask

	initial begin
		int blk, w, h;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Reset setting 2x2 on 640 wide: four pixels of the first row, which close no block.
		for (int i = 0; i < 4; i++) send_pixel(8'hFF, 8'h00, 8'h80);
		setup(1, 3, 2);
		send_pixel(8'h00, 8'hFF, 8'h01);
		random_frames(6, 1);
		setup(0, 0, 0);
		send_pixel(8'h12, 8'h34, 8'h56);
		send_pixel(8'hFF, 8'hFF, 8'hFF);
		setup(16, 16, 16);
		random_frames(256, 1);
		setup(31, 8, 8191);
		send_pixel(8'h01, 8'h02, 8'h03);
		setup(4, 3, 5);
		random_frames(16, 0);
		setup(3, 7, 7);
		random_frames(12, 2);
		// A write in mid frame restarts position counting.
		drain();
		write_reg(REG_IMAGE_WIDTH, 6);
		random_frames(14, 0);
		while (pixels_sent < 780) begin
			blk = $urandom_range(1, 5);
			w = $urandom_range(1, 14);
			h = $urandom_range(1, 8);
			if ($urandom_range(0, 9) == 0) w = 4096;
			setup(CFG_W'(blk), CFG_W'(w), CFG_W'(h));
			if (pixels_sent > 700) calm = 1'b1;
			random_frames((w == 4096) ? 60 : $urandom_range(1, 3) * w * h + $urandom_range(0, 5),
				$urandom_range(0, 2));
		end
		calm = 1'b1;
		drain();
		if (board.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end
endmodule
`default_nettype wire
